@@ design/lfucp_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lfucp_pkg
// Shared types and constants for the LFU size cache policy block.
// ---------------------------------------------------------------------------
package lfucp_pkg;

    localparam int KEY_W  = 16;
    localparam int USE_W  = 16;
    localparam int SLOT_W = 3;

    localparam logic [USE_W-1:0] USE_LIMIT = 16'd65000;
    localparam logic [USE_W-1:0] USE_NEW   = 16'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_UPDATE
    } t_state;

endpackage
`default_nettype wire

@@ design/lfucp_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lfucp_req_if / lfucp_rsp_if
// Valid/ready channels for lookup requests and their results.
// ---------------------------------------------------------------------------
interface lfucp_req_if
    import lfucp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_size;

    modport source (output valid, output key_size, input ready);
    modport sink   (input valid, input key_size, output ready);
endinterface

interface lfucp_rsp_if
    import lfucp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              hit;
    logic              cached;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
    logic [USE_W-1:0]  use_count;

    modport source (output valid, output hit, output cached, output slot,
                    output evicted, output evicted_key, output use_count,
                    input ready);
    modport sink   (input valid, input hit, input cached, input slot,
                    input evicted, input evicted_key, input use_count,
                    output ready);
endinterface
`default_nettype wire

@@ design/lfucp_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lfucp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lfucp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ design/lfu_size_cache_policy.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lfu_size_cache_policy
// Fully associative LFU cache policy keyed by a 16-bit size. Slot keys and
// use counts sit in one RAM; each request scans every slot, then writes back.
//
//   channel | dir | payload
//   i_req   | in  | key_size
//   o_rsp   | out | hit, cached, slot, evicted, evicted_key, use_count
//
// A request runs from the accept through one read per slot over the single RAM
// read port, a drain step for the last read data and the write-back step, then
// returns to idle. The result is registered in the write-back step. One request
// is in flight at a time, so no RAM access overlaps another.
// Reset clears per-slot valid bits at once; no clearing pass is needed.
// A result waits in the output register; the next request is accepted
// meanwhile and holds in the write-back step until the register is free.
// ---------------------------------------------------------------------------
module lfu_size_cache_policy
    import lfucp_pkg::*;
#(
    parameter int ENTRIES = 8
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    lfucp_req_if.sink   i_req,
    lfucp_rsp_if.source o_rsp
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int DW = KEY_W + USE_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    t_state r_state, n_state;

    logic [IW-1:0]    r_idx;
    logic             r_cmp_vld;
    logic [IW-1:0]    r_cmp_idx;
    logic             r_rd_valid;
    logic [ENTRIES-1:0] r_valid;
    logic [KEY_W-1:0] r_key;

    logic             r_found;
    logic [IW-1:0]    r_found_idx;
    logic [USE_W-1:0] r_found_uses;
    logic             r_free;
    logic [IW-1:0]    r_free_idx;
    logic [IW-1:0]    r_min_idx;
    logic [USE_W-1:0] r_low_uses;
    logic [KEY_W-1:0] r_min_key;

    logic              r_rsp_vld;
    logic              r_hit, r_cached, r_evicted;
    logic [SLOT_W-1:0] r_slot;
    logic [KEY_W-1:0]  r_ev_key;
    logic [USE_W-1:0]  r_use;

    logic              n_hit, n_cached, n_evicted;
    logic [IW-1:0]     n_slot_idx;
    logic [KEY_W-1:0]  n_ev_key;
    logic [USE_W-1:0]  n_use;

    logic [DW-1:0]     w_rd_data;
    logic [KEY_W-1:0]  w_rd_key;
    logic [USE_W-1:0]  w_rd_uses;
    logic              w_rd_en;
    logic              w_wr_en;
    logic [IW-1:0]     w_wr_addr;
    logic [DW-1:0]     w_wr_data;
    logic              w_out_free;
    logic              w_accept;
    logic [USE_W:0]    w_inc;
    logic [USE_W-1:0]  w_sat;
    logic [IW+SLOT_W-1:0] w_slot_wide;

    lfucp_ram #(
        .WIDTH (DW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_rsp_vld || o_rsp.ready;
    assign w_rd_en     = (r_state == S_SCAN);

    // never-written slots read as free
    assign w_rd_key  = r_rd_valid ? w_rd_data[DW-1:USE_W] : '0;
    assign w_rd_uses = r_rd_valid ? w_rd_data[USE_W-1:0] : '0;

    assign w_inc = {1'b0, r_found_uses} + {{USE_W{1'b0}}, 1'b1};
    assign w_sat = (w_inc > {1'b0, USE_LIMIT}) ? USE_LIMIT : w_inc[USE_W-1:0];

    always_comb begin
        n_state    = r_state;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_found_idx;
        w_wr_data  = {r_key, USE_NEW};
        n_hit      = 1'b0;
        n_cached   = 1'b0;
        n_evicted  = 1'b0;
        n_slot_idx = '0;
        n_ev_key   = '0;
        n_use      = '0;

        if (r_key != '0) begin
            if (r_found) begin
                n_hit      = 1'b1;
                n_cached   = 1'b1;
                n_slot_idx = r_found_idx;
                n_use      = w_sat;
                w_wr_addr  = r_found_idx;
                w_wr_data  = {r_key, w_sat};
            end else if (r_free) begin
                n_cached   = 1'b1;
                n_slot_idx = r_free_idx;
                n_use      = USE_NEW;
                w_wr_addr  = r_free_idx;
            end else if (r_low_uses >= USE_NEW) begin
                n_cached   = 1'b1;
                n_evicted  = 1'b1;
                n_slot_idx = r_min_idx;
                n_ev_key   = r_min_key;
                n_use      = USE_NEW;
                w_wr_addr  = r_min_idx;
            end else begin
                n_use      = USE_NEW;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (w_out_free) begin
                    w_wr_en = n_cached;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_slot_wide = {{SLOT_W{1'b0}}, n_slot_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_vld <= 1'b0;
            r_valid   <= '0;
            r_rsp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_free    <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= w_rd_en;
            if (w_accept) begin
                r_idx   <= '0;
                r_found <= 1'b0;
                r_free  <= 1'b0;
            end else if (w_rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_cmp_vld) begin
                if (w_rd_key == r_key) begin
                    r_found <= 1'b1;
                end
                if (w_rd_key == '0) begin
                    r_free <= 1'b1;
                end
            end
            if (w_wr_en) begin
                r_valid[w_wr_addr] <= 1'b1;
            end
            if (r_state == S_UPDATE && w_out_free) begin
                r_rsp_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= i_req.key_size;
        end
        if (w_rd_en) begin
            r_cmp_idx  <= r_idx;
            r_rd_valid <= r_valid[r_idx];
        end
        if (r_cmp_vld) begin
            // highest matching slot wins
            if (w_rd_key == r_key) begin
                r_found_idx  <= r_cmp_idx;
                r_found_uses <= w_rd_uses;
            end
            if (w_rd_key == '0 && !r_free) begin
                r_free_idx <= r_cmp_idx;
            end
            if (r_cmp_idx == '0 || w_rd_uses < r_low_uses) begin
                r_min_idx  <= r_cmp_idx;
                r_low_uses <= w_rd_uses;
                r_min_key  <= w_rd_key;
            end
        end
        if (r_state == S_UPDATE && w_out_free) begin
            r_hit     <= n_hit;
            r_cached  <= n_cached;
            r_evicted <= n_evicted;
            r_slot    <= w_slot_wide[SLOT_W-1:0];
            r_ev_key  <= n_ev_key;
            r_use     <= n_use;
        end
    end

    assign o_rsp.valid       = r_rsp_vld;
    assign o_rsp.hit         = r_hit;
    assign o_rsp.cached      = r_cached;
    assign o_rsp.slot        = r_slot;
    assign o_rsp.evicted     = r_evicted;
    assign o_rsp.evicted_key = r_ev_key;
    assign o_rsp.use_count   = r_use;

`ifndef NO_ASSERTIONS
    a_wr_only_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == S_UPDATE))
        else $error("RAM write outside write-back step");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCAN) && (r_idx == '0))
        else $error("accepted request did not start a scan");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) && w_wr_en && n_evicted |-> !r_free && !r_found)
        else $error("eviction with a free or matching slot");

    a_use_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_vld |-> (r_use <= USE_LIMIT) && (!r_hit || r_cached))
        else $error("result use count or hit flag inconsistent");
`endif

endmodule
`default_nettype wire
